// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; each macro takes a clock and reset by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/flvrs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the tag resync scanner.
// Depends on nothing; used by the top level and the checker.
package flvrs_pkg;

   localparam int BUF_DEPTH = 65536;
   localparam int PTR_W     = $clog2(BUF_DEPTH);
   localparam int CNT_W     = PTR_W + 1;

   localparam logic [7:0] TAG_AUDIO  = 8'h08;
   localparam logic [7:0] TAG_VIDEO  = 8'h09;
   localparam logic [7:0] TAG_SCRIPT = 8'h12;

   localparam int HDR_LEN    = 11;
   localparam int TAG_EXTRA  = 15;
   localparam logic [15:0] MAX_SIZE_RESET = 16'd65521;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POLL = 1'b1;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } flvrs_req_type;

   typedef struct packed {
      logic        tag_found;
      logic [7:0]  tag_type;
      logic [15:0] data_size;
      logic [31:0] timestamp_raw;
      logic [31:0] tag_offset;
      logic        overflow;
   } flvrs_rsp_type;

endpackage

// ===== src/flvrs_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module flvrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== src/flv_tag_resync_scanner.sv =====
`timescale 1ns / 1ps
// Top level of the tag resync scanner: byte buffer, scan sequencer, result register.
// Depends on flvrs_pkg and flvrs_ram.
//
// Usage:
//   req channel: one word per item, opcode push (data_byte stored) or poll.
//   rsp channel: exactly one word per item, with at most one confirmed tag;
//     overflow marks a pushed byte dropped because the buffer was full.
//   csr port: csr_we writes max_data_size; write only while idle.
// Operation: the block takes one item at a time. After acceptance it runs a scan
//   sequencer over the byte buffer RAM, whose single read port has registered
//   read data and sets the pace: each stored byte is read through the ISSUE
//   and WAIT states. A confirmed tag reads 15 bytes.
// Reset: pointers, counts, scan point and stream position clear, the size
//   limit returns to 65521. The buffer RAM is not cleared; no entry is read
//   before it was written.
// Stall: a result waits in the output register while rsp_ready is low; the
//   next item is still accepted and scanned, and its result waits behind it.
module flv_tag_resync_scanner (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  flvrs_pkg::flvrs_req_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output flvrs_pkg::flvrs_rsp_type rsp_data,
   input  logic                    csr_we,
   input  logic [15:0]             csr_wdata
);
   import flvrs_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_ISSUE = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [2:0] PH_TYPE = 3'd0;
   localparam logic [2:0] PH_SIZE = 3'd1;
   localparam logic [2:0] PH_SID  = 3'd2;
   localparam logic [2:0] PH_PREV = 3'd3;
   localparam logic [2:0] PH_TS   = 3'd4;

   logic [2:0]       st_ff, st_in;
   logic [2:0]       ph_ff, ph_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [CNT_W-1:0] off_ff, off_in;
   logic [31:0]      acc_ff, acc_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic [31:0]      base_ff, base_in;
   logic [15:0]      max_ff;
   logic [7:0]       type_ff, type_in;
   logic [CNT_W-1:0] size_ff, size_in;
   flvrs_rsp_type    wk_ff, wk_in;
   flvrs_rsp_type    res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic             wr_en;
   logic [PTR_W-1:0] wr_addr;
   logic             rd_en;
   logic [PTR_W-1:0] rd_addr;
   logic [7:0]       rd_data;

   logic             accept;
   logic [31:0]      acc_n;
   logic [24:0]      sz_ext;
   logic [CNT_W-1:0] remain;
   logic [CNT_W-1:0] consumed;
   logic             type_ok;

   assign req_ready = (st_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = res_ff;

   // store pushed bytes behind the newest kept byte
   assign wr_en   = accept && (req_data.opcode == OP_PUSH) && (fill_ff < CNT_W'(BUF_DEPTH));
   assign wr_addr = head_ff + fill_ff[PTR_W-1:0];
   assign rd_en   = (st_ff == ST_ISSUE);
   assign rd_addr = head_ff + off_ff[PTR_W-1:0];

   flvrs_ram #(
      .WIDTH(8),
      .DEPTH(BUF_DEPTH)
   ) u_buf (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_data.data_byte),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign acc_n    = {acc_ff[23:0], rd_data};
   assign sz_ext   = {1'b0, acc_n[23:0]};
   assign remain   = fill_ff - scan_ff;
   assign consumed = scan_ff + size_ff + CNT_W'(TAG_EXTRA);
   assign type_ok  = (rd_data == TAG_AUDIO) || (rd_data == TAG_VIDEO) ||
                     (rd_data == TAG_SCRIPT);

   // scan sequencer
   always_comb begin
      st_in        = st_ff;
      ph_in        = ph_ff;
      cnt_in       = cnt_ff;
      off_in       = off_ff;
      acc_in       = acc_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      scan_in      = scan_ff;
      base_in      = base_ff;
      type_in      = type_ff;
      size_in      = size_ff;
      wk_in        = wk_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;

      // drain the result word
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               wk_in = '0;
               if (req_data.opcode == OP_PUSH) begin
                  if (wr_en) begin
                     fill_in = fill_ff + 1'b1;
                  end else begin
                     wk_in.overflow = 1'b1;
                  end
               end
               st_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (remain >= CNT_W'(TAG_EXTRA)) begin
               ph_in  = PH_TYPE;
               off_in = scan_ff;
               cnt_in = 3'd1;
               acc_in = '0;
               st_in  = ST_ISSUE;
            end else begin
               st_in = ST_DONE;
            end
         end
         ST_ISSUE: begin
            st_in = ST_WAIT;
         end
         ST_WAIT: begin
            acc_in = acc_n;
            off_in = off_ff + 1'b1;
            cnt_in = cnt_ff - 1'b1;
            st_in  = ST_ISSUE;
            if (cnt_ff == 3'd1) begin
               acc_in = '0;
               case (ph_ff)
                  PH_TYPE: begin
                     if (type_ok) begin
                        type_in = rd_data;
                        ph_in   = PH_SIZE;
                        off_in  = scan_ff + 1'b1;
                        cnt_in  = 3'd3;
                     end else begin
                        scan_in = scan_ff + 1'b1;
                        st_in   = ST_CHECK;
                     end
                  end
                  PH_SIZE: begin
                     if ((sz_ext > 25'(max_ff)) ||
                         ((sz_ext + 25'(TAG_EXTRA)) > 25'(BUF_DEPTH))) begin
                        scan_in = scan_ff + 1'b1;
                        st_in   = ST_CHECK;
                     end else if (25'(remain) < (sz_ext + 25'(TAG_EXTRA))) begin
                        st_in = ST_DONE;
                     end else begin
                        size_in = CNT_W'(sz_ext);
                        ph_in   = PH_SID;
                        off_in  = scan_ff + CNT_W'(8);
                        cnt_in  = 3'd3;
                     end
                  end
                  PH_SID: begin
                     if (acc_n[23:0] != 24'd0) begin
                        scan_in = scan_ff + 1'b1;
                        st_in   = ST_CHECK;
                     end else begin
                        ph_in  = PH_PREV;
                        off_in = scan_ff + CNT_W'(HDR_LEN) + size_ff;
                        cnt_in = 3'd4;
                     end
                  end
                  PH_PREV: begin
                     if (acc_n != (32'(size_ff) + 32'(HDR_LEN))) begin
                        scan_in = scan_ff + 1'b1;
                        st_in   = ST_CHECK;
                     end else begin
                        ph_in  = PH_TS;
                        off_in = scan_ff + CNT_W'(4);
                        cnt_in = 3'd4;
                     end
                  end
                  default: begin
                     // confirmed tag: report it and drop it and the bytes before it from the buffer
                     wk_in.tag_found     = 1'b1;
                     wk_in.tag_type      = type_ff;
                     wk_in.data_size     = size_ff[15:0];
                     wk_in.timestamp_raw = acc_n;
                     wk_in.tag_offset    = base_ff + 32'(scan_ff);
                     head_in = head_ff + consumed[PTR_W-1:0];
                     fill_in = fill_ff - consumed;
                     base_in = base_ff + 32'(consumed);
                     scan_in = '0;
                     st_in   = ST_DONE;
                  end
               endcase
            end
         end
         ST_DONE: begin
            // hand the word over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               res_in       = wk_ff;
               rsp_valid_in = 1'b1;
               st_in        = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         scan_ff      <= '0;
         base_ff      <= '0;
         max_ff       <= MAX_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         scan_ff      <= scan_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
      end
   end

   // hold working payload
   always_ff @(posedge clock) begin
      ph_ff   <= ph_in;
      cnt_ff  <= cnt_in;
      off_ff  <= off_in;
      acc_ff  <= acc_in;
      type_ff <= type_in;
      size_ff <= size_in;
      wk_ff   <= wk_in;
      res_ff  <= res_in;
   end

endmodule

// ===== src/flvrs_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the tag resync scanner, bound to the top level.
// Depends on flvrs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module flvrs_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input flvrs_pkg::flvrs_req_type req_data,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input flvrs_pkg::flvrs_rsp_type rsp_data
);
   import flvrs_pkg::*;

   // a stalled result word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp word changed while stalled")

   // one item at a time: no accept right after an accept
   `ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready, "req accepted twice in a row")

   // a word without a tag carries zero tag fields
   `ASSERT_NOW(a_no_tag_zero, clock, reset, rsp_valid && !rsp_data.tag_found, (rsp_data.tag_type == 8'd0) && (rsp_data.data_size == 16'd0) && (rsp_data.timestamp_raw == 32'd0) && (rsp_data.tag_offset == 32'd0), "tag fields set without a tag")

   // a reported tag has a known type
   `ASSERT_NOW(a_tag_type, clock, reset, rsp_valid && rsp_data.tag_found, (rsp_data.tag_type == TAG_AUDIO) || (rsp_data.tag_type == TAG_VIDEO) || (rsp_data.tag_type == TAG_SCRIPT), "reported tag has bad type")

endmodule

bind flv_tag_resync_scanner flvrs_checker u_flvrs_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .req_data (req_data),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);
